>>> hdl/tdr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// triangle depth resolve block. Used by every module under hdl but tdr_ram; no dependencies.
package tdr_pkg;

    // Face table geometry.
    localparam int MAX_FACES        = 256;
    localparam int FACE_BITS        = $clog2(MAX_FACES);
    localparam int FACE_CNT_BITS    = FACE_BITS + 1;
    localparam int CORNER_DEPTH     = 3 * MAX_FACES;
    localparam int CORNER_ADDR_BITS = $clog2(CORNER_DEPTH);

    // Number formats.
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 10;
    localparam int XY_BITS    = 32;
    localparam int Z_BITS     = 31;
    localparam int RGB_BITS   = 24;
    localparam int FC_BITS    = 9;
    localparam int PITCH_BITS = 31;
    localparam int CORNER_WORD = 2 * XY_BITS + Z_BITS;

    // Datapath widths.
    localparam int PIX_BITS    = COORD_BITS + PITCH_BITS + 2;
    localparam int DIFF_BITS   = XY_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int NORM_BITS   = PROD_BITS + 4;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int NUM_BITS    = 2 * FRAC_BITS + 1;
    localparam int REM_BITS    = ACC_BITS;
    localparam int QUO_BITS    = NUM_BITS + 1;
    localparam int INV_BITS    = NUM_BITS + 1;
    localparam int STEP_BITS   = $clog2(NUM_BITS + 1);

    localparam int ONE = 1 << FRAC_BITS;
    localparam logic [Z_BITS-1:0] DEPTH_MAX = '1;

    // Configuration port.
    localparam int PADDR_BITS = 5;
    localparam logic [2:0] REG_FACE_COUNT = 3'd0;
    localparam logic [2:0] REG_VIEW_LEFT  = 3'd1;
    localparam logic [2:0] REG_VIEW_TOP   = 3'd2;
    localparam logic [2:0] REG_PITCH_X    = 3'd3;
    localparam logic [2:0] REG_PITCH_Y    = 3'd4;

    localparam logic [XY_BITS-1:0]    RST_VIEW_LEFT = 32'hFFFF_0000;
    localparam logic [XY_BITS-1:0]    RST_VIEW_TOP  = 32'h0001_0000;
    localparam logic [PITCH_BITS-1:0] RST_PITCH     = 31'd262;

    // Item actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SHADE = 1'b1;

    // Corner code that addresses nothing.
    localparam logic [1:0] CORNER_NONE = 2'd3;

    // Division stages of one face.
    localparam logic [2:0] DIV_WS = 3'd0;
    localparam logic [2:0] DIV_WT = 3'd1;
    localparam logic [2:0] DIV_IA = 3'd2;
    localparam logic [2:0] DIV_IB = 3'd3;
    localparam logic [2:0] DIV_IC = 3'd4;
    localparam logic [2:0] DIV_ZD = 3'd5;

    // Multiplier schedule length.
    localparam logic [2:0] MUL_STEPS = 3'd6;

    typedef struct packed {
        logic                 pix_load;
        logic                 load_wr;
        logic [1:0]           rd_corner;
        logic                 cap_a;
        logic                 cap_b;
        logic                 cap_c;
        logic                 diff;
        logic                 mul_en;
        logic [2:0]           mul_sel;
        logic                 acc_en;
        logic [2:0]           acc_sel;
        logic                 norm;
        logic                 div_start;
        logic                 div_take;
        logic [2:0]           div_stage;
        logic                 cmp;
        logic                 out_load;
        logic [FACE_BITS-1:0] face;
    } cmd_t;

    typedef struct packed {
        logic miss;
        logic div_busy;
    } status_t;

    typedef struct packed {
        logic [RGB_BITS-1:0]  rgb;
        logic                 found;
        logic [FACE_BITS-1:0] face;
        logic [Z_BITS-1:0]    depth;
    } result_t;

endpackage

>>> hdl/triangle_depth_resolve_core.sv
// Top level of the triangle depth resolve block: configuration registers,
// input handshake and output register. Depends on tdr_pkg, tdr_ctrl, tdr_datapath.
//
// Usage. Items enter on the s_ channel (valid/ready). A load item writes one
// corner of one face into the face table (none for corner code 3); it makes no
// result. A shade item makes exactly one result on the m_ channel: the
// colour, index and depth of the strictly nearest covering face, or zero
// colour, index 0 and maximum depth when no face covers the pixel.
// For each tested face, a shade item reads the corners and forms the edge
// products; when the pixel lies inside it, the shared one-bit-per-cycle
// divider runs two 17-step and four 33-step divisions. Shade items are
// processed one at a time; s_ready is low while a pixel is worked on.
// The result sits in an output register, so load items are taken while a
// result waits; a stalled receiver only holds the next shade item at its end.
// Reset clears the controller, the output valid flag and the configuration
// to its reset values; face tables hold no reset value and must be loaded
// before use. The user must write configuration over the APB port only
// while idle; the block itself does not enforce it.
module triangle_depth_resolve_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tdr_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Input items.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [7:0]                           s_face_slot,
    input  logic [1:0]                           s_corner,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   s_screen_x,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   s_screen_y,
    input  logic [tdr_pkg::Z_BITS-1:0]           s_corner_depth,
    input  logic [tdr_pkg::RGB_BITS-1:0]         s_face_rgb,
    input  logic [9:0]                           s_pixel_col,
    input  logic [9:0]                           s_pixel_row,
    // Result items.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tdr_pkg::RGB_BITS-1:0]         m_pixel_rgb,
    output logic                                 m_covered,
    output logic [7:0]                           m_nearest_face,
    output logic [tdr_pkg::Z_BITS-1:0]           m_nearest_depth
);

    // Configuration registers.
    logic [tdr_pkg::FC_BITS-1:0]        face_count_reg;
    logic signed [tdr_pkg::XY_BITS-1:0] view_left_reg;
    logic signed [tdr_pkg::XY_BITS-1:0] view_top_reg;
    logic [tdr_pkg::PITCH_BITS-1:0]     pitch_x_reg;
    logic [tdr_pkg::PITCH_BITS-1:0]     pitch_y_reg;
    logic                               cfg_wr;
    logic [2:0]                         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[tdr_pkg::PADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_count_reg <= '0;
            view_left_reg  <= tdr_pkg::RST_VIEW_LEFT;
            view_top_reg   <= tdr_pkg::RST_VIEW_TOP;
            pitch_x_reg    <= tdr_pkg::RST_PITCH;
            pitch_y_reg    <= tdr_pkg::RST_PITCH;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tdr_pkg::REG_FACE_COUNT: face_count_reg <= pwdata[tdr_pkg::FC_BITS-1:0];
                tdr_pkg::REG_VIEW_LEFT:  view_left_reg  <= pwdata;
                tdr_pkg::REG_VIEW_TOP:   view_top_reg   <= pwdata;
                tdr_pkg::REG_PITCH_X:    pitch_x_reg    <= pwdata[tdr_pkg::PITCH_BITS-1:0];
                tdr_pkg::REG_PITCH_Y:    pitch_y_reg    <= pwdata[tdr_pkg::PITCH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (cfg_idx)
            tdr_pkg::REG_FACE_COUNT: prdata = 32'(face_count_reg);
            tdr_pkg::REG_VIEW_LEFT:  prdata = view_left_reg;
            tdr_pkg::REG_VIEW_TOP:   prdata = view_top_reg;
            tdr_pkg::REG_PITCH_X:    prdata = 32'(pitch_x_reg);
            tdr_pkg::REG_PITCH_Y:    prdata = 32'(pitch_y_reg);
            default:                 prdata = '0;
        endcase
    end

    // Controller and datapath.
    tdr_pkg::cmd_t    cmd;
    tdr_pkg::status_t status;
    tdr_pkg::result_t result;
    logic             m_valid_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    tdr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_action  (s_action),
        .s_ready   (s_ready),
        .face_count(face_count_reg),
        .out_free  (out_free),
        .status    (status),
        .cmd       (cmd)
    );

    tdr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .s_face_slot   (s_face_slot),
        .s_corner      (s_corner),
        .s_screen_x    (s_screen_x),
        .s_screen_y    (s_screen_y),
        .s_corner_depth(s_corner_depth),
        .s_face_rgb    (s_face_rgb),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .view_left     (view_left_reg),
        .view_top      (view_top_reg),
        .pitch_x       (pitch_x_reg),
        .pitch_y       (pitch_y_reg)
    );

    // Output register.
    logic [tdr_pkg::RGB_BITS-1:0] rgb_reg;
    logic                         covered_reg;
    logic [7:0]                   face_reg;
    logic [tdr_pkg::Z_BITS-1:0]   depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rgb_reg     <= result.rgb;
            covered_reg <= result.found;
            face_reg    <= result.found ? 8'(result.face) : 8'd0;
            depth_reg   <= result.found ? result.depth : tdr_pkg::DEPTH_MAX;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_rgb     = rgb_reg;
    assign m_covered       = covered_reg;
    assign m_nearest_face  = face_reg;
    assign m_nearest_depth = depth_reg;

    // An uncovered pixel reports the empty result.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !covered_reg |->
            rgb_reg == '0 && face_reg == 8'd0 && depth_reg == tdr_pkg::DEPTH_MAX)
        else $error("uncovered pixel with a non-empty result");

    // A shade item holds off the next item.
    a_shade_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == tdr_pkg::ACT_SHADE |=> !s_ready)
        else $error("item accepted while a pixel is being resolved");

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("result register overwritten while stalled");

endmodule

>>> hdl/tdr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/tdr_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on tdr_pkg for widths.
module tdr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          frac,
    input  logic [tdr_pkg::REM_BITS-1:0]  init_rem,
    input  logic [tdr_pkg::NUM_BITS-1:0]  num,
    input  logic [tdr_pkg::REM_BITS-1:0]  den,
    input  logic [tdr_pkg::STEP_BITS-1:0] steps,
    output logic                          busy,
    output logic [tdr_pkg::QUO_BITS-1:0]  quo
);

    logic [tdr_pkg::REM_BITS-1:0]  rem_reg, rem_next;
    logic [tdr_pkg::NUM_BITS-1:0]  num_reg;
    logic [tdr_pkg::REM_BITS-1:0]  den_reg;
    logic [tdr_pkg::QUO_BITS-1:0]  quo_reg;
    logic [tdr_pkg::STEP_BITS-1:0] cnt_reg;
    logic                          first_reg;
    logic                          frac_reg;
    logic [tdr_pkg::REM_BITS:0]    trial;
    logic [tdr_pkg::REM_BITS:0]    diff;
    logic                          ge;

    // A fraction division compares the unshifted remainder first.
    always_comb begin
        if (frac_reg && first_reg) begin
            trial = {1'b0, rem_reg};
        end else begin
            trial = {rem_reg, num_reg[tdr_pkg::NUM_BITS-1]};
        end
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[tdr_pkg::REM_BITS-1:0] : trial[tdr_pkg::REM_BITS-1:0];
    end

    // Step control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= steps;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= init_rem;
            num_reg   <= num;
            den_reg   <= den;
            quo_reg   <= '0;
            first_reg <= 1'b1;
            frac_reg  <= frac;
        end else if (cnt_reg != '0) begin
            rem_reg   <= rem_next;
            num_reg   <= {num_reg[tdr_pkg::NUM_BITS-2:0], 1'b0};
            quo_reg   <= {quo_reg[tdr_pkg::QUO_BITS-2:0], ge};
            first_reg <= 1'b0;
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

>>> hdl/tdr_ctrl.sv
// Sequencer for the triangle depth resolve block: walks the faces of one
// pixel through the datapath steps. Depends on tdr_pkg.
module tdr_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_action,
    output logic                        s_ready,
    input  logic [tdr_pkg::FC_BITS-1:0] face_count,
    input  logic                        out_free,
    input  tdr_pkg::status_t            status,
    output tdr_pkg::cmd_t               cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD0    = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_RD2    = 4'd3;
    localparam logic [3:0] S_CAPC   = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_NORM   = 4'd7;
    localparam logic [3:0] S_TEST   = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DWAIT  = 4'd10;
    localparam logic [3:0] S_CMP    = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;
    localparam logic [3:0] S_COL    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]                          state_reg, state_next;
    logic [tdr_pkg::FACE_CNT_BITS-1:0]   face_reg, face_next;
    logic [2:0]                          mcnt_reg, mcnt_next;
    logic [2:0]                          stage_reg, stage_next;
    logic [tdr_pkg::FACE_CNT_BITS-1:0]   n_faces;
    logic [tdr_pkg::FACE_CNT_BITS-1:0]   face_inc;

    // Counts above the table size test the whole table.
    assign n_faces = (tdr_pkg::FACE_CNT_BITS'(face_count) >
                      tdr_pkg::FACE_CNT_BITS'(tdr_pkg::MAX_FACES)) ?
                     tdr_pkg::FACE_CNT_BITS'(tdr_pkg::MAX_FACES) :
                     tdr_pkg::FACE_CNT_BITS'(face_count);
    assign face_inc = face_reg + 1'b1;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        face_next  = face_reg;
        mcnt_next  = mcnt_reg;
        stage_next = stage_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.face   = face_reg[tdr_pkg::FACE_BITS-1:0];
        cmd.div_stage = stage_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == tdr_pkg::ACT_SHADE) begin
                        cmd.pix_load = 1'b1;
                        face_next    = '0;
                        state_next   = (n_faces == '0) ? S_COL : S_RD0;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_RD0: begin
                cmd.rd_corner = 2'd0;
                state_next    = S_RD1;
            end
            S_RD1: begin
                cmd.rd_corner = 2'd1;
                cmd.cap_a     = 1'b1;
                state_next    = S_RD2;
            end
            S_RD2: begin
                cmd.rd_corner = 2'd2;
                cmd.cap_b     = 1'b1;
                state_next    = S_CAPC;
            end
            S_CAPC: begin
                cmd.cap_c  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                mcnt_next  = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                // Product k is formed in step k and summed in step k+1.
                cmd.mul_en  = mcnt_reg != tdr_pkg::MUL_STEPS;
                cmd.mul_sel = mcnt_reg;
                cmd.acc_en  = mcnt_reg != 3'd0;
                cmd.acc_sel = mcnt_reg - 1'b1;
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == tdr_pkg::MUL_STEPS) begin
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                cmd.norm   = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (status.miss) begin
                    state_next = S_NEXT;
                end else begin
                    stage_next = tdr_pkg::DIV_WS;
                    state_next = S_DSTART;
                end
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (!status.div_busy) begin
                    cmd.div_take = 1'b1;
                    if (stage_reg == tdr_pkg::DIV_ZD) begin
                        state_next = S_CMP;
                    end else begin
                        stage_next = stage_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                face_next  = face_inc;
                state_next = (face_inc == n_faces) ? S_COL : S_RD0;
            end
            S_COL: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            face_reg  <= '0;
            mcnt_reg  <= '0;
            stage_reg <= tdr_pkg::DIV_WS;
        end else begin
            state_reg <= state_next;
            face_reg  <= face_next;
            mcnt_reg  <= mcnt_next;
            stage_reg <= stage_next;
        end
    end

endmodule

>>> hdl/tdr_datapath.sv
// Datapath of the triangle depth resolve block: face tables, pixel centre,
// edge products, barycentric weights, depth and the nearest-hit tracker.
// Depends on tdr_pkg, tdr_ram and tdr_div.
module tdr_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tdr_pkg::cmd_t                        cmd,
    output tdr_pkg::status_t                     status,
    output tdr_pkg::result_t                     result,
    input  logic [7:0]                           s_face_slot,
    input  logic [1:0]                           s_corner,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   s_screen_x,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   s_screen_y,
    input  logic [tdr_pkg::Z_BITS-1:0]           s_corner_depth,
    input  logic [tdr_pkg::RGB_BITS-1:0]         s_face_rgb,
    input  logic [9:0]                           s_pixel_col,
    input  logic [9:0]                           s_pixel_row,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   view_left,
    input  logic signed [tdr_pkg::XY_BITS-1:0]   view_top,
    input  logic [tdr_pkg::PITCH_BITS-1:0]       pitch_x,
    input  logic [tdr_pkg::PITCH_BITS-1:0]       pitch_y
);

    localparam int XY  = tdr_pkg::XY_BITS;
    localparam int ZB  = tdr_pkg::Z_BITS;
    localparam int DB  = tdr_pkg::DIFF_BITS;
    localparam int PB  = tdr_pkg::PROD_BITS;
    localparam int AB  = tdr_pkg::ACC_BITS;
    localparam int NB  = tdr_pkg::NORM_BITS;
    localparam int RB  = tdr_pkg::REM_BITS;
    localparam int WB  = tdr_pkg::WEIGHT_BITS;
    localparam int PXB = tdr_pkg::PIX_BITS;
    localparam int CAB = tdr_pkg::CORNER_ADDR_BITS;
    localparam logic [tdr_pkg::NUM_BITS-1:0] ONE_SQ = {1'b1, {(2*tdr_pkg::FRAC_BITS){1'b0}}};

    // Saturate a wide pixel coordinate to the signed coordinate range.
    function automatic logic signed [XY-1:0] sat_xy(input logic signed [PXB-1:0] v);
        logic [PXB-XY:0] top;
        top = v[PXB-1:XY-1];
        if (top == '0 || top == '1) begin
            return v[XY-1:0];
        end else if (v[PXB-1]) begin
            return {1'b1, {(XY-1){1'b0}}};
        end else begin
            return {1'b0, {(XY-1){1'b1}}};
        end
    endfunction

    // ---------------- face tables ----------------
    logic                           slot_ok;
    logic [CAB-1:0]                 waddr, raddr;
    logic [tdr_pkg::CORNER_WORD-1:0] corner_rdata;
    logic [tdr_pkg::RGB_BITS-1:0]   colour_rdata;
    logic                           corner_we, colour_we;
    logic [tdr_pkg::FACE_BITS-1:0]  slot_idx;

    assign slot_ok  = {1'b0, s_face_slot} < 9'(tdr_pkg::MAX_FACES);
    assign slot_idx = tdr_pkg::FACE_BITS'(s_face_slot);
    assign corner_we = cmd.load_wr && slot_ok && (s_corner != tdr_pkg::CORNER_NONE);
    assign colour_we = cmd.load_wr && slot_ok && (s_corner == 2'd0);
    assign waddr = CAB'(slot_idx) + CAB'(slot_idx) + CAB'(slot_idx) + CAB'(s_corner);
    assign raddr = CAB'(cmd.face) + CAB'(cmd.face) + CAB'(cmd.face) + CAB'(cmd.rd_corner);

    tdr_ram #(
        .WIDTH(tdr_pkg::CORNER_WORD),
        .DEPTH(tdr_pkg::CORNER_DEPTH)
    ) u_corner_ram (
        .aclk (aclk),
        .we   (corner_we),
        .waddr(waddr),
        .wdata({s_screen_x, s_screen_y, s_corner_depth}),
        .raddr(raddr),
        .rdata(corner_rdata)
    );

    logic [tdr_pkg::FACE_BITS-1:0] best_reg;

    tdr_ram #(
        .WIDTH(tdr_pkg::RGB_BITS),
        .DEPTH(tdr_pkg::MAX_FACES)
    ) u_colour_ram (
        .aclk (aclk),
        .we   (colour_we),
        .waddr(slot_idx),
        .wdata(s_face_rgb),
        .raddr(best_reg),
        .rdata(colour_rdata)
    );

    // ---------------- pixel centre ----------------
    logic [tdr_pkg::COORD_BITS-1:0] col, row;
    logic [PXB-1:0]                 colp, rowp;
    logic signed [PXB-1:0]          px_wide, py_wide;
    logic signed [XY-1:0]           px_reg, py_reg;

    assign col  = s_pixel_col[tdr_pkg::COORD_BITS-1:0];
    assign row  = s_pixel_row[tdr_pkg::COORD_BITS-1:0];
    assign colp = PXB'(col) * PXB'(pitch_x);
    assign rowp = PXB'(row) * PXB'(pitch_y);
    assign px_wide = PXB'(view_left) + $signed(PXB'(pitch_x >> 1)) + $signed(colp);
    assign py_wide = PXB'(view_top) - $signed(PXB'(pitch_y >> 1)) - $signed(rowp);

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            px_reg <= sat_xy(px_wide);
            py_reg <= sat_xy(py_wide);
        end
    end

    // ---------------- corner capture ----------------
    logic signed [XY-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [ZB-1:0]        za_reg, zb_reg, zc_reg;
    logic signed [XY-1:0] rd_x, rd_y;
    logic [ZB-1:0]        rd_z;

    assign rd_x = corner_rdata[2*XY+ZB-1:XY+ZB];
    assign rd_y = corner_rdata[XY+ZB-1:ZB];
    // A zero depth reads as the smallest depth.
    assign rd_z = (corner_rdata[ZB-1:0] == '0) ? ZB'(1) : corner_rdata[ZB-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            ax_reg <= rd_x;
            ay_reg <= rd_y;
            za_reg <= rd_z;
        end
        if (cmd.cap_b) begin
            bx_reg <= rd_x;
            by_reg <= rd_y;
            zb_reg <= rd_z;
        end
        if (cmd.cap_c) begin
            cx_reg <= rd_x;
            cy_reg <= rd_y;
            zc_reg <= rd_z;
        end
    end

    // ---------------- edge differences ----------------
    logic signed [DB-1:0] e1_reg, e2_reg, e3_reg, e4_reg, dx_reg, dy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            e1_reg <= DB'(by_reg) - DB'(cy_reg);
            e2_reg <= DB'(cx_reg) - DB'(bx_reg);
            e3_reg <= DB'(cy_reg) - DB'(ay_reg);
            e4_reg <= DB'(ax_reg) - DB'(cx_reg);
            dx_reg <= DB'(px_reg) - DB'(cx_reg);
            dy_reg <= DB'(py_reg) - DB'(cy_reg);
        end
    end

    // ---------------- shared multiplier and sums ----------------
    logic signed [DB-1:0] mul_a, mul_b;
    logic signed [PB-1:0] prod_reg;
    logic signed [AB-1:0] prod_ext;
    logic signed [AB-1:0] d_reg, ns_reg, nt_reg;

    always_comb begin
        case (cmd.mul_sel)
            3'd0: begin mul_a = e1_reg; mul_b = e4_reg; end
            3'd1: begin mul_a = e2_reg; mul_b = e3_reg; end
            3'd2: begin mul_a = e1_reg; mul_b = dx_reg; end
            3'd3: begin mul_a = e2_reg; mul_b = dy_reg; end
            3'd4: begin mul_a = e3_reg; mul_b = dx_reg; end
            default: begin mul_a = e4_reg; mul_b = dy_reg; end
        endcase
    end

    assign prod_ext = AB'(prod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_en) begin
            case (cmd.acc_sel)
                3'd0: d_reg  <= prod_ext;
                3'd1: d_reg  <= d_reg - prod_ext;
                3'd2: ns_reg <= prod_ext;
                3'd3: ns_reg <= ns_reg + prod_ext;
                3'd4: nt_reg <= prod_ext;
                default: nt_reg <= nt_reg + prod_ext;
            endcase
        end
    end

    // ---------------- sign normalization and inside test ----------------
    logic signed [NB-1:0] dw, nsw, ntw, nuw;
    logic signed [NB-1:0] dn_reg, nsn_reg, ntn_reg, nun_reg;

    assign dw  = NB'(d_reg);
    assign nsw = NB'(ns_reg);
    assign ntw = NB'(nt_reg);
    assign nuw = dw - nsw - ntw;

    always_ff @(posedge aclk) begin
        if (cmd.norm) begin
            if (d_reg[AB-1]) begin
                dn_reg  <= -dw;
                nsn_reg <= -nsw;
                ntn_reg <= -ntw;
                nun_reg <= -nuw;
            end else begin
                dn_reg  <= dw;
                nsn_reg <= nsw;
                ntn_reg <= ntw;
                nun_reg <= nuw;
            end
        end
    end

    assign status.miss = (dn_reg == '0) || nsn_reg[NB-1] || ntn_reg[NB-1] || nun_reg[NB-1];

    // ---------------- divisions ----------------
    logic [WB-1:0]                       ws_reg, wt_reg, wu;
    logic [tdr_pkg::INV_BITS-1:0]        inv_reg;
    logic [ZB-1:0]                       z_reg;
    logic                                div_frac;
    logic [RB-1:0]                       div_rem, div_den;
    logic [tdr_pkg::NUM_BITS-1:0]        div_num;
    logic [tdr_pkg::STEP_BITS-1:0]       div_steps;
    logic [tdr_pkg::QUO_BITS-1:0]        div_quo;
    logic                                div_busy;

    assign wu = WB'(tdr_pkg::ONE) - ws_reg - wt_reg;

    always_comb begin
        div_frac  = 1'b0;
        div_rem   = '0;
        div_num   = '0;
        div_den   = RB'(za_reg);
        div_steps = tdr_pkg::STEP_BITS'(tdr_pkg::NUM_BITS);
        case (cmd.div_stage)
            tdr_pkg::DIV_WS: begin
                div_frac  = 1'b1;
                div_rem   = nsn_reg[RB-1:0];
                div_den   = dn_reg[RB-1:0];
                div_steps = tdr_pkg::STEP_BITS'(tdr_pkg::FRAC_BITS + 1);
            end
            tdr_pkg::DIV_WT: begin
                div_frac  = 1'b1;
                div_rem   = ntn_reg[RB-1:0];
                div_den   = dn_reg[RB-1:0];
                div_steps = tdr_pkg::STEP_BITS'(tdr_pkg::FRAC_BITS + 1);
            end
            tdr_pkg::DIV_IA: begin
                div_num = {ws_reg, {tdr_pkg::FRAC_BITS{1'b0}}};
                div_den = RB'(za_reg);
            end
            tdr_pkg::DIV_IB: begin
                div_num = {wt_reg, {tdr_pkg::FRAC_BITS{1'b0}}};
                div_den = RB'(zb_reg);
            end
            tdr_pkg::DIV_IC: begin
                div_num = {wu, {tdr_pkg::FRAC_BITS{1'b0}}};
                div_den = RB'(zc_reg);
            end
            default: begin
                // A zero inverse depth yields an all-ones quotient and saturates.
                div_num = ONE_SQ;
                div_den = RB'(inv_reg);
            end
        endcase
    end

    tdr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .frac    (div_frac),
        .init_rem(div_rem),
        .num     (div_num),
        .den     (div_den),
        .steps   (div_steps),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign status.div_busy = div_busy;

    always_ff @(posedge aclk) begin
        if (cmd.div_take) begin
            case (cmd.div_stage)
                tdr_pkg::DIV_WS: ws_reg  <= div_quo[WB-1:0];
                tdr_pkg::DIV_WT: wt_reg  <= div_quo[WB-1:0];
                tdr_pkg::DIV_IA: inv_reg <= tdr_pkg::INV_BITS'(div_quo);
                tdr_pkg::DIV_IB: inv_reg <= inv_reg + tdr_pkg::INV_BITS'(div_quo);
                tdr_pkg::DIV_IC: inv_reg <= inv_reg + tdr_pkg::INV_BITS'(div_quo);
                default: begin
                    z_reg <= (div_quo > tdr_pkg::QUO_BITS'(tdr_pkg::DEPTH_MAX)) ?
                             tdr_pkg::DEPTH_MAX : div_quo[ZB-1:0];
                end
            endcase
        end
    end

    // ---------------- nearest hit ----------------
    logic          found_reg;
    logic [ZB-1:0] best_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_depth_reg <= tdr_pkg::DEPTH_MAX;
        end else if (cmd.pix_load) begin
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_depth_reg <= tdr_pkg::DEPTH_MAX;
        end else if (cmd.cmp && (!found_reg || z_reg < best_depth_reg)) begin
            // Strictly nearer only, so the earlier face keeps a tie.
            found_reg      <= 1'b1;
            best_reg       <= cmd.face;
            best_depth_reg <= z_reg;
        end
    end

    assign result.rgb   = found_reg ? colour_rdata : '0;
    assign result.found = found_reg;
    assign result.face  = best_reg;
    assign result.depth = best_depth_reg;

endmodule

>>> dv/triangle_depth_resolve_core_test.sv
// Self-checking testbench for triangle_depth_resolve_core: loads face corners, shades pixels
// and checks every result against a predictor of the nearest covering face.
// Depends on tdr_pkg and the RTL under hdl.
module triangle_depth_resolve_core_test;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [23:0] rgb;
        logic        covered;
        logic [7:0]  face;
        logic [30:0] depth;
    } pixel_t;

    localparam int IDLE_LIMIT = 200000;
    localparam int ITEM_GOAL  = 1050;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite, pready;
    logic [tdr_pkg::PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        s_valid, s_ready, s_action;
    logic [7:0]  s_face_slot;
    logic [1:0]  s_corner;
    logic signed [31:0] s_screen_x, s_screen_y;
    logic [30:0] s_corner_depth;
    logic [23:0] s_face_rgb;
    logic [9:0]  s_pixel_col, s_pixel_row;
    logic        m_valid, m_ready, m_covered;
    logic [23:0] m_pixel_rgb;
    logic [7:0]  m_nearest_face;
    logic [30:0] m_nearest_depth;

    // Predictor state: face table and configuration as the block should hold them.
    longint          tbl_x[3*tdr_pkg::MAX_FACES];
    longint          tbl_y[3*tdr_pkg::MAX_FACES];
    longint unsigned tbl_z[3*tdr_pkg::MAX_FACES];
    logic [23:0]     tbl_rgb[tdr_pkg::MAX_FACES];
    int unsigned     cfg_faces;
    longint          cfg_left, cfg_top;
    longint unsigned cfg_pitch_x, cfg_pitch_y;

    pixel_t      pending_pixels[$];
    int          error_count = 0;
    int          items_sent;
    int          idle_cycles = 0;
    bit          calm;

    triangle_depth_resolve_core DUT (.*);

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver readiness, stalling at random unless in a calm stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // Watchdog on cycles without any accepted item or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result checker: each result against the oldest expected pixel.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result item with no shade item pending");
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_pixel_rgb !== want.rgb) begin
                    $error("pixel_rgb expected %h actual %h", want.rgb, m_pixel_rgb);
                    error_count++;
                end
                if (m_covered !== want.covered) begin
                    $error("covered expected %b actual %b", want.covered, m_covered);
                    error_count++;
                end
                if (m_nearest_face !== want.face) begin
                    $error("nearest_face expected %0d actual %0d", want.face, m_nearest_face);
                    error_count++;
                end
                if (m_nearest_depth !== want.depth) begin
                    $error("nearest_depth expected %h actual %h", want.depth, m_nearest_depth);
                    error_count++;
                end
            end
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint centre_x(int unsigned col);
        return clamp32(cfg_left + longint'(cfg_pitch_x >> 1) + longint'(col * cfg_pitch_x));
    endfunction

    function automatic longint centre_y(int unsigned row);
        return clamp32(cfg_top - longint'(cfg_pitch_y >> 1) - longint'(row * cfg_pitch_y));
    endfunction

    // Barycentric coverage and perspective-correct depth of one face.
    function automatic bit face_covers(int f, longint px, longint py,
                                       output longint unsigned depth);
        longint ax, ay, bx, by, cx, cy;
        longint unsigned za, zb, zc, ws, wt, wu, inv, z;
        wide_t d, ns, nt, nu;
        ax = tbl_x[3*f];   ay = tbl_y[3*f];
        bx = tbl_x[3*f+1]; by = tbl_y[3*f+1];
        cx = tbl_x[3*f+2]; cy = tbl_y[3*f+2];
        za = tbl_z[3*f];   zb = tbl_z[3*f+1]; zc = tbl_z[3*f+2];
        d  = wide_t'(by - cy) * wide_t'(ax - cx) + wide_t'(cx - bx) * wide_t'(ay - cy);
        if (d == 0) return 1'b0;
        ns = wide_t'(by - cy) * wide_t'(px - cx) + wide_t'(cx - bx) * wide_t'(py - cy);
        nt = wide_t'(cy - ay) * wide_t'(px - cx) + wide_t'(ax - cx) * wide_t'(py - cy);
        nu = d - ns - nt;
        if (d < 0) begin
            d = -d; ns = -ns; nt = -nt; nu = -nu;
        end
        if (ns < 0 || nt < 0 || nu < 0) return 1'b0;
        ws = longint'((ns <<< tdr_pkg::FRAC_BITS) / d);
        wt = longint'((nt <<< tdr_pkg::FRAC_BITS) / d);
        wu = tdr_pkg::ONE - ws - wt;
        // A zero depth reads as the smallest depth.
        if (za == 0) za = 1;
        if (zb == 0) zb = 1;
        if (zc == 0) zc = 1;
        inv = ws * tdr_pkg::ONE / za + wt * tdr_pkg::ONE / zb + wu * tdr_pkg::ONE / zc;
        if (inv == 0) begin
            z = tdr_pkg::DEPTH_MAX;
        end else begin
            z = longint'(tdr_pkg::ONE) * tdr_pkg::ONE / inv;
            if (z > tdr_pkg::DEPTH_MAX) z = tdr_pkg::DEPTH_MAX;
        end
        depth = z;
        return 1'b1;
    endfunction

    // Nearest covering face of one pixel; the earlier face wins a tie.
    function automatic pixel_t resolve_pixel(logic [9:0] col, logic [9:0] row);
        pixel_t res;
        longint px, py;
        longint unsigned z, best_z;
        int unsigned n, best;
        bit found;
        px = centre_x(col);
        py = centre_y(row);
        n = (cfg_faces > tdr_pkg::MAX_FACES) ? tdr_pkg::MAX_FACES : cfg_faces;
        found = 1'b0;
        best = 0;
        best_z = tdr_pkg::DEPTH_MAX;
        for (int f = 0; f < n; f++) begin
            if (face_covers(f, px, py, z) && (!found || z < best_z)) begin
                found = 1'b1;
                best = f;
                best_z = z;
            end
        end
        res.rgb     = found ? tbl_rgb[best] : '0;
        res.covered = found;
        res.face    = found ? best[7:0] : '0;
        res.depth   = found ? best_z[30:0] : tdr_pkg::DEPTH_MAX;
        return res;
    endfunction

    // Register write over the configuration port; the block must be idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= tdr_pkg::PADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tdr_pkg::REG_FACE_COUNT: cfg_faces   = value[8:0];
            tdr_pkg::REG_VIEW_LEFT:  cfg_left    = longint'(signed'(value));
            tdr_pkg::REG_VIEW_TOP:   cfg_top     = longint'(signed'(value));
            tdr_pkg::REG_PITCH_X:    cfg_pitch_x = value[30:0];
            tdr_pkg::REG_PITCH_Y:    cfg_pitch_y = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_view(longint left, longint top, longint unsigned ptx,
                            longint unsigned pty);
        write_reg(tdr_pkg::REG_VIEW_LEFT, left[31:0]);
        write_reg(tdr_pkg::REG_VIEW_TOP, top[31:0]);
        write_reg(tdr_pkg::REG_PITCH_X, {1'b0, ptx[30:0]});
        write_reg(tdr_pkg::REG_PITCH_Y, {1'b0, pty[30:0]});
    endtask

    // Sends one item and updates the predictor when it is accepted.
    task automatic send_item(logic action, logic [7:0] slot, logic [1:0] corner,
                             longint x, longint y, logic [30:0] z, logic [23:0] rgb,
                             logic [9:0] col, logic [9:0] row);
        int k;
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action; s_face_slot <= slot; s_corner <= corner;
        s_screen_x <= x[31:0]; s_screen_y <= y[31:0]; s_corner_depth <= z;
        s_face_rgb <= rgb; s_pixel_col <= col; s_pixel_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (action == tdr_pkg::ACT_SHADE) begin
            pending_pixels = {pending_pixels, resolve_pixel(col, row)};
        end else if (corner != tdr_pkg::CORNER_NONE) begin
            k = 3 * slot + corner;
            tbl_x[k] = longint'(signed'(x[31:0]));
            tbl_y[k] = longint'(signed'(y[31:0]));
            tbl_z[k] = z;
            if (corner == 2'd0) tbl_rgb[slot] = rgb;
        end
    endtask

    task automatic load_corner(int slot, int corner, longint x, longint y,
                               longint unsigned z, logic [23:0] rgb);
        send_item(tdr_pkg::ACT_LOAD, slot[7:0], corner[1:0], x, y, z[30:0], rgb, '0, '0);
    endtask

    task automatic shade(int col, int row);
        send_item(tdr_pkg::ACT_SHADE, '0, '0, 0, 0, '0, '0, col[9:0], row[9:0]);
    endtask

    // Waits until every result is back and the last load has settled.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic longint rand_depth();
        if ($urandom_range(9) == 0) return $urandom_range(32'h7FFF_FFFF, 1);
        return $urandom_range(32'h0020_0000, 32'h0000_4000);
    endfunction

    // Random face whose corners lie around pixels of the low corner of the view.
    task automatic load_random_face(int slot);
        int col, row, order[3];
        longint sx, sy;
        logic [23:0] rgb;
        col = $urandom_range(15);
        row = $urandom_range(15);
        rgb = $urandom;
        order = '{0, 1, 2};
        order.shuffle();
        foreach (order[i]) begin
            sx = centre_x(col) + longint'($urandom_range(40)) * cfg_pitch_x
                 - longint'($urandom_range(40)) * cfg_pitch_x;
            sy = centre_y(row) + longint'($urandom_range(40)) * cfg_pitch_y
                 - longint'($urandom_range(40)) * cfg_pitch_y;
            if ($urandom_range(19) == 0) sx = $signed($urandom);
            if ($urandom_range(15) == 0) begin
                load_corner(slot, tdr_pkg::CORNER_NONE, $signed($urandom), $signed($urandom),
                            $urandom, $urandom);
            end
            load_corner(slot, order[i], clamp32(sx), clamp32(sy), rand_depth(), rgb);
        end
    endtask

    // Reset state, faces with ties, zero depth, a flat face and extreme pixels.
    task automatic test_directed();
        longint lo, hi;
        shade(0, 0);
        shade(1023, 1023);
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        // A face spanning the whole view, loaded twice for a depth tie.
        for (int f = 0; f < 2; f++) begin
            load_corner(f, 0, lo, hi, 0, 24'hFFFFFF);
            load_corner(f, 1, lo, lo, 31'h7FFF_FFFF, 24'hFFFFFF);
            load_corner(f, 2, hi, 0, 65536, 24'hFFFFFF);
        end
        // A flat face: all corners on one line.
        load_corner(2, 0, 0, 0, 65536, 24'h0000FF);
        load_corner(2, 1, 65536, 65536, 65536, 24'h0000FF);
        load_corner(2, 2, 131072, 131072, 65536, 24'h0000FF);
        load_corner(3, tdr_pkg::CORNER_NONE, hi, lo, 1, 24'h123456);
        drain();
        write_reg(tdr_pkg::REG_FACE_COUNT, 32'd3);
        shade(0, 0);
        shade(1023, 1023);
        shade(511, 0);
        shade(0, 1023);
        shade(250, 250);
        drain();
    endtask

    // Extreme register values on a table holding just the directed faces.
    task automatic test_register_extremes();
        set_view(-64'sd2147483648, 64'sd2147483647, 0, 0);
        shade(1023, 1023);
        drain();
        set_view(64'sd2147483647, -64'sd2147483648, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        shade(0, 0);
        shade(1023, 1023);
        drain();
        write_reg(tdr_pkg::REG_FACE_COUNT, 32'd0);
        shade(5, 5);
        drain();
    endtask

    // Every face slot loaded, then shaded with the full and the oversized face count.
    task automatic test_full_table();
        calm = 1'b1;
        set_view(-65536, 65536, 4096, 4096);
        for (int f = 0; f < tdr_pkg::MAX_FACES; f++) load_random_face(f);
        calm = 1'b0;
        drain();
        write_reg(tdr_pkg::REG_FACE_COUNT, tdr_pkg::MAX_FACES);
        shade(3, 4);
        shade(8, 8);
        drain();
        write_reg(tdr_pkg::REG_FACE_COUNT, 32'd511);
        shade(10, 2);
        drain();
    endtask

    // Phases of a random view and a few fresh faces, then random pixels.
    task automatic test_random_scenes();
        int faces, phase;
        longint unsigned ptx, pty;
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            calm = (phase % 6 == 5);
            ptx = ($urandom_range(3) == 0) ? $urandom_range(31'h7FFF_FFFF) : $urandom_range(4096, 1);
            pty = ($urandom_range(3) == 0) ? ptx : $urandom_range(4096, 1);
            set_view($signed($urandom_range(32'h0200_0000)) - 64'sd16777216,
                     $signed($urandom_range(32'h0200_0000)) - 64'sd16777216, ptx, pty);
            faces = $urandom_range(6, 1);
            write_reg(tdr_pkg::REG_FACE_COUNT, faces);
            for (int f = 0; f < faces; f++) load_random_face(f);
            repeat ($urandom_range(12, 6)) begin
                if ($urandom_range(9) == 0) shade($urandom_range(1023), $urandom_range(1023));
                else shade($urandom_range(15), $urandom_range(15));
                if ($urandom_range(4) == 0) load_corner(faces + $urandom_range(20),
                    $urandom_range(3), $signed($urandom), $signed($urandom),
                    $urandom, $urandom);
            end
            drain();
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_action = tdr_pkg::ACT_LOAD; s_face_slot = '0; s_corner = '0;
        s_screen_x = '0; s_screen_y = '0; s_corner_depth = '0; s_face_rgb = '0;
        s_pixel_col = '0; s_pixel_row = '0;
        calm = 1'b0;
        items_sent = 0;
        cfg_faces = 0;
        cfg_left = -65536;
        cfg_top = 65536;
        cfg_pitch_x = 262;
        cfg_pitch_y = 262;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_extremes();
        test_full_table();
        test_random_scenes();

        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> triangle_depth_resolve_core.f
hdl/tdr_pkg.sv
hdl/tdr_ram.sv
hdl/tdr_div.sv
hdl/tdr_ctrl.sv
hdl/tdr_datapath.sv
hdl/triangle_depth_resolve_core.sv
dv/triangle_depth_resolve_core_test.sv
